@@ hdl/gtr_pkg.sv @@
// Shared types, constants and the glyph ROM of the text rasterizer.
package gtr_pkg;

	localparam logic [7:0] LEAD_BYTE = 8'hC3;
	localparam logic [7:0] UML_UPPER = 8'h96;
	localparam logic [7:0] UML_LOWER = 8'hB6;
	localparam logic [7:0] UML_SLOT = 8'h80;
	localparam logic [10:0] CURSOR_MAX = 11'd2047;

	localparam logic [1:0] FUNC_TEXT = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	localparam logic [1:0] REG_ORIGIN_X = 2'd0;
	localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
	localparam logic [1:0] REG_SCALE = 2'd2;

	typedef struct packed {
		logic load_item;
		logic adv;
		logic lead_set;
		logic lead_clr;
		logic draw_uml;
		logic draw_byte;
		logic pix_step;
		logic pix_rd;
		logic pix_wr;
		logic clr_init;
		logic clr_step;
		logic rd_issue;
		logic out_load;
	} gtr_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic lead;
		logic byte_uml;
		logic byte_lead;
		logic end_flag;
		logic hit;
		logic pix_last;
		logic clr_last;
		logic out_free;
	} gtr_sts_t;

	// Five columns of seven rows, column i in bits [8i+7:8i], row 0 in the lowest bit.
	function automatic logic [39:0] glyph_bits(input logic [7:0] code);
		logic [39:0] g;
		unique case (code)
			8'h21: g = 40'h00_00_5f_00_00;
			8'h25: g = 40'h23_13_08_64_62;
			8'h2d: g = 40'h08_08_08_08_08;
			8'h2e: g = 40'h00_00_60_60_00;
			8'h3a: g = 40'h00_00_36_36_00;
			8'h30: g = 40'h3e_45_49_51_3e;
			8'h31: g = 40'h00_40_7f_42_00;
			8'h32: g = 40'h46_49_51_61_42;
			8'h33: g = 40'h31_4b_45_41_21;
			8'h34: g = 40'h10_7f_12_14_18;
			8'h35: g = 40'h39_45_45_45_27;
			8'h36: g = 40'h30_49_49_4a_3c;
			8'h37: g = 40'h03_05_09_71_01;
			8'h38: g = 40'h36_49_49_49_36;
			8'h39: g = 40'h1e_29_49_49_06;
			8'h41: g = 40'h7e_11_11_11_7e;
			8'h42: g = 40'h36_49_49_49_7f;
			8'h43: g = 40'h22_41_41_41_3e;
			8'h44: g = 40'h1c_22_41_41_7f;
			8'h45: g = 40'h41_49_49_49_7f;
			8'h46: g = 40'h01_09_09_09_7f;
			8'h47: g = 40'h7a_49_49_41_3e;
			8'h48: g = 40'h7f_08_08_08_7f;
			8'h49: g = 40'h00_41_7f_41_00;
			8'h4a: g = 40'h01_3f_41_40_20;
			8'h4b: g = 40'h41_22_14_08_7f;
			8'h4c: g = 40'h40_40_40_40_7f;
			8'h4d: g = 40'h7f_02_0c_02_7f;
			8'h4e: g = 40'h7f_10_08_04_7f;
			8'h4f: g = 40'h3e_41_41_41_3e;
			8'h50: g = 40'h06_09_09_09_7f;
			8'h51: g = 40'h5e_21_51_41_3e;
			8'h52: g = 40'h46_29_19_09_7f;
			8'h53: g = 40'h31_49_49_49_46;
			8'h54: g = 40'h01_01_7f_01_01;
			8'h55: g = 40'h3f_40_40_40_3f;
			8'h56: g = 40'h1f_20_40_20_1f;
			8'h57: g = 40'h3f_40_38_40_3f;
			8'h58: g = 40'h63_14_08_14_63;
			8'h59: g = 40'h07_08_70_08_07;
			8'h5a: g = 40'h43_45_49_51_61;
			8'h80: g = 40'h3e_41_41_41_3e;
			default: g = 40'h0;
		endcase
		return g;
	endfunction

endpackage

@@ hdl/gtr_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module gtr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4736
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ hdl/gtr_datapath.sv @@
// Datapath: item and config registers, cursor, glyph walker, store access and output register.
module gtr_datapath import gtr_pkg::*; #(
	parameter int PANEL_WIDTH = 128,
	parameter int PANEL_HEIGHT = 296
) (
	input  logic        clk,
	input  logic        arst_n,
	input  gtr_cmd_t    cmd,
	output gtr_sts_t    sts,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic [23:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata
);
	localparam int ROW_BYTES = (PANEL_WIDTH + 7) / 8;
	localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
	localparam int AW = $clog2(STORE_BYTES);

	logic [8:0] ox_q;
	logic [6:0] oy_q;
	logic [3:0] sc_q;
	logic [10:0] cursor_q;
	logic lead_q;
	logic [1:0] func_q;
	logic [7:0] byte_q;
	logic end_q;
	logic [12:0] ridx_q;
	logic [7:0] code_q;
	logic phase_q, d_q;
	logic [2:0] col_q, row_q;
	logic [3:0] a_q, b_q;
	logic [AW-1:0] addr_q, clr_addr_q;
	logic [7:0] mask_q;
	logic fill_q;
	logic out_valid_q;
	logic [7:0] rdata_q;
	logic [10:0] cur_out_q;

	logic [39:0] gbits;
	logic [7:0] gcol;
	logic bit0, inner_last, row_adv, glyph_end;
	logic [3:0] lim, lim_m1;
	logic [6:0] offx;
	logic [11:0] x12;
	logic [9:0] y10;
	logic in_x, in_y;
	logic [7:0] px;
	logic [AW-1:0] pix_addr;
	logic [11:0] adv_sum;
	logic ridx_ok;
	logic ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0] ram_wdata, ram_rdata;

	assign gbits = glyph_bits(code_q);
	assign gcol = gbits[{col_q, 3'b000} +: 8];
	assign bit0 = gcol[row_q] && (sc_q != 4'd0);
	assign lim = (sc_q == 4'd0) ? 4'd1 : sc_q;
	assign lim_m1 = lim - 4'd1;
	assign inner_last = (a_q == lim_m1) && (b_q == lim_m1);
	assign row_adv = !bit0 || inner_last;
	assign glyph_end = row_adv && (row_q == 3'd6) && (col_q == 3'd4);

	always_comb begin
		if (!phase_q) begin
			offx = 7'(col_q) * 7'(sc_q) + 7'(a_q);
			y10 = 10'(oy_q) + 10'(row_q) * 10'(sc_q) + 10'(b_q);
		end else begin
			offx = (d_q ? 7'(sc_q) * 7'd3 : 7'(sc_q)) + 7'(a_q);
			y10 = 10'(oy_q) + 10'(b_q) - 10'({sc_q, 1'b0});
		end
	end

	assign x12 = {1'b0, cursor_q} + 12'(offx);
	assign in_x = x12 < 12'(PANEL_HEIGHT);
	assign in_y = !y10[9] && (y10 < 10'(PANEL_WIDTH));
	assign px = 8'(PANEL_WIDTH - 1) - y10[7:0];
	assign pix_addr = AW'(px >> 3) + AW'(x12) * AW'(ROW_BYTES);
	assign adv_sum = {1'b0, cursor_q} + 12'(sc_q) * 12'd6;
	assign ridx_ok = 32'(ridx_q) < STORE_BYTES;

	assign sts.func = func_q;
	assign sts.lead = lead_q;
	assign sts.byte_uml = (byte_q == UML_UPPER) || (byte_q == UML_LOWER);
	assign sts.byte_lead = byte_q == LEAD_BYTE;
	assign sts.end_flag = end_q;
	assign sts.hit = (phase_q ? 1'b1 : bit0) && in_x && in_y;
	assign sts.pix_last = phase_q ? (d_q && inner_last) : (glyph_end && code_q != UML_SLOT);
	assign sts.clr_last = clr_addr_q == AW'(STORE_BYTES - 1);
	assign sts.out_free = !out_valid_q || m_tready;

	assign ram_we = cmd.clr_step || cmd.pix_wr;
	assign ram_waddr = cmd.clr_step ? clr_addr_q : addr_q;
	assign ram_wdata = cmd.clr_step ? {8{fill_q}} : (ram_rdata & ~mask_q);
	assign ram_re = cmd.pix_rd || cmd.rd_issue;
	assign ram_raddr = cmd.pix_rd ? pix_addr : AW'(ridx_q);

	gtr_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q <= '0;
			oy_q <= '0;
			sc_q <= 4'd1;
			cursor_q <= '0;
			lead_q <= 1'b0;
			clr_addr_q <= '0;
			fill_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ORIGIN_X: ox_q <= cfg_data;
					REG_ORIGIN_Y: oy_q <= cfg_data[6:0];
					REG_SCALE: sc_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (cmd.load_item && s_tuser == FUNC_TEXT && s_tdata[8]) begin
				cursor_q <= 11'(ox_q);
				lead_q <= 1'b0;
			end
			if (cmd.adv) begin
				cursor_q <= adv_sum[11] ? CURSOR_MAX : adv_sum[10:0];
			end
			if (cmd.lead_set) begin
				lead_q <= 1'b1;
			end
			if (cmd.lead_clr) begin
				lead_q <= 1'b0;
			end
			if (cmd.clr_init) begin
				clr_addr_q <= '0;
				fill_q <= s_tdata[9];
			end else if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			func_q <= s_tuser;
			byte_q <= s_tdata[7:0];
			end_q <= s_tlast;
			ridx_q <= s_tdata[22:10];
		end
		if (cmd.draw_uml || cmd.draw_byte) begin
			code_q <= cmd.draw_uml ? UML_SLOT : byte_q;
			phase_q <= 1'b0;
			d_q <= 1'b0;
			col_q <= '0;
			row_q <= '0;
			a_q <= '0;
			b_q <= '0;
		end else if (cmd.pix_step) begin
			if (!phase_q) begin
				if (!row_adv) begin
					if (b_q == lim_m1) begin
						b_q <= '0;
						a_q <= a_q + 4'd1;
					end else begin
						b_q <= b_q + 4'd1;
					end
				end else begin
					a_q <= '0;
					b_q <= '0;
					if (row_q == 3'd6) begin
						row_q <= '0;
						if (col_q == 3'd4) begin
							phase_q <= 1'b1;
						end else begin
							col_q <= col_q + 3'd1;
						end
					end else begin
						row_q <= row_q + 3'd1;
					end
				end
			end else begin
				if (!inner_last) begin
					if (b_q == lim_m1) begin
						b_q <= '0;
						a_q <= a_q + 4'd1;
					end else begin
						b_q <= b_q + 4'd1;
					end
				end else begin
					a_q <= '0;
					b_q <= '0;
					d_q <= 1'b1;
				end
			end
		end
		if (cmd.pix_rd) begin
			addr_q <= pix_addr;
			mask_q <= 8'h80 >> px[2:0];
		end
		if (cmd.out_load) begin
			rdata_q <= (func_q == FUNC_READ && ridx_ok) ? ram_rdata : 8'h00;
			cur_out_q <= cursor_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {5'b0, cur_out_q, rdata_q};

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || m_tready))
		else $error("result loaded over an untaken beat");
	a_out_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not shown");
	a_wr_mask: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pix_wr |-> $onehot(mask_q))
		else $error("pixel write without a single-bit mask");
endmodule

@@ hdl/gtr_ctrl.sv @@
// Controller state machine that sequences items, glyph drawing and store sweeps.
module gtr_ctrl import gtr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	input  logic [1:0] s_tuser,
	output logic     s_tready,
	input  gtr_sts_t sts,
	output gtr_cmd_t cmd
);
	localparam logic [2:0] ST_CLR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_T1 = 3'd2;
	localparam logic [2:0] ST_T2 = 3'd3;
	localparam logic [2:0] ST_PIX = 3'd4;
	localparam logic [2:0] ST_WR = 3'd5;
	localparam logic [2:0] ST_FIN = 3'd6;

	logic [2:0] state_q, state_d;
	logic from_item_q, from_item_d;

	assign s_tready = state_q == ST_IDLE;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		from_item_d = from_item_q;
		unique case (state_q)
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = from_item_q ? ST_FIN : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					priority case (s_tuser)
						FUNC_TEXT: state_d = ST_T1;
						FUNC_CLEAR: begin
							cmd.clr_init = 1'b1;
							from_item_d = 1'b1;
							state_d = ST_CLR;
						end
						default: begin
							from_item_d = 1'b1;
							state_d = ST_FIN;
						end
					endcase
				end
			end
			ST_T1: begin
				if (sts.lead) begin
					cmd.lead_clr = 1'b1;
					if (sts.byte_uml) begin
						cmd.draw_uml = 1'b1;
						state_d = ST_PIX;
					end else begin
						cmd.adv = 1'b1;
						state_d = ST_T2;
					end
				end else begin
					state_d = ST_T2;
				end
			end
			ST_T2: begin
				if (sts.byte_lead) begin
					if (sts.end_flag) begin
						cmd.adv = 1'b1;
					end else begin
						cmd.lead_set = 1'b1;
					end
					state_d = ST_FIN;
				end else begin
					cmd.draw_byte = 1'b1;
					state_d = ST_PIX;
				end
			end
			ST_PIX: begin
				if (sts.hit) begin
					cmd.pix_rd = 1'b1;
					state_d = ST_WR;
				end else begin
					cmd.pix_step = 1'b1;
					if (sts.pix_last) begin
						cmd.adv = 1'b1;
						state_d = ST_FIN;
					end
				end
			end
			ST_WR: begin
				cmd.pix_wr = 1'b1;
				cmd.pix_step = 1'b1;
				if (sts.pix_last) begin
					cmd.adv = 1'b1;
					state_d = ST_FIN;
				end else begin
					state_d = ST_PIX;
				end
			end
			ST_FIN: begin
				cmd.rd_issue = sts.func == FUNC_READ && from_item_q;
				from_item_d = 1'b0;
				if (!from_item_q && sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			from_item_q <= 1'b0;
		end else begin
			state_q <= state_d;
			from_item_q <= from_item_d;
		end
	end

	// A read item reaches FIN with from_item_q set in the idle state.
	a_wr_after_pix: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WR |-> $past(state_q) == ST_PIX)
		else $error("pixel write not preceded by its read");
	a_ram_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pix_wr || cmd.clr_step) |-> (state_q == ST_WR || state_q == ST_CLR))
		else $error("store written outside a write state");
	a_fin_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !from_item_q && sts.out_free) |=> state_q == ST_IDLE)
		else $error("finished item did not return to idle");
endmodule

@@ hdl/glyph_text_rasterizer.sv @@
// Top level of the 5x7 glyph text rasterizer with rotated 1-bit frame store.
// A text byte is drawn pixel by pixel (at most 35*scale^2 drawn pixels per glyph), each
// pixel a read-modify-write of one store byte: read in PIX, written back in WR.
// A clear writes one store byte per cycle (4736 at default size); a read fetches its byte in FIN.
// One item is worked at a time; the next is taken while the last result waits for m_tready.
// After reset the store is swept to zero with s_tready low.
module glyph_text_rasterizer import gtr_pkg::*; #(
	parameter int PANEL_WIDTH = 128,
	parameter int PANEL_HEIGHT = 296
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // text_byte, string_start, fill_white, read_index
	input  logic [1:0]  s_tuser,  // func
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // read_data, cursor_position
);
	gtr_cmd_t cmd;
	gtr_sts_t sts;

	gtr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gtr_datapath #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);
endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the glyph text rasterizer: random strings, clears and read-backs.
module tb_top;
	import gtr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_SIZE = 4736;
	localparam int IDLE_LIMIT = 40000;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  txt;
		logic        start;
		logic        stop;
		logic        white;
		logic [12:0] ridx;
	} op_t;

	typedef struct packed {
		logic [7:0]  rdata;
		logic [10:0] cursor;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [8:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	op_t    pending_ops[$];
	reply_t expected_replies[$];

	logic [7:0] shadow_store[STORE_SIZE];
	int         shadow_cursor;
	bit         shadow_lead;
	int         org_x, org_y, scale;

	int send_idle_pct = 30, recv_idle_pct = 50;
	int hold_cycles = 0;
	int idle_count = 0;
	int errors = 0;
	int n_text = 0, n_clear = 0, n_read = 0, n_checked = 0;

	glyph_text_rasterizer DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// Font columns in order 0..4, row 0 in the lowest bit.
	function automatic logic [39:0] font_cols(input int code);
		case (code)
			8'h21: return {8'h00, 8'h00, 8'h5f, 8'h00, 8'h00};
			8'h25: return {8'h62, 8'h64, 8'h08, 8'h13, 8'h23};
			8'h2d: return {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
			8'h2e: return {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
			8'h3a: return {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
			8'h30: return {8'h3e, 8'h51, 8'h49, 8'h45, 8'h3e};
			8'h31: return {8'h00, 8'h42, 8'h7f, 8'h40, 8'h00};
			8'h32: return {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
			8'h33: return {8'h21, 8'h41, 8'h45, 8'h4b, 8'h31};
			8'h34: return {8'h18, 8'h14, 8'h12, 8'h7f, 8'h10};
			8'h35: return {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
			8'h36: return {8'h3c, 8'h4a, 8'h49, 8'h49, 8'h30};
			8'h37: return {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
			8'h38: return {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
			8'h39: return {8'h06, 8'h49, 8'h49, 8'h29, 8'h1e};
			8'h41: return {8'h7e, 8'h11, 8'h11, 8'h11, 8'h7e};
			8'h42: return {8'h7f, 8'h49, 8'h49, 8'h49, 8'h36};
			8'h43: return {8'h3e, 8'h41, 8'h41, 8'h41, 8'h22};
			8'h44: return {8'h7f, 8'h41, 8'h41, 8'h22, 8'h1c};
			8'h45: return {8'h7f, 8'h49, 8'h49, 8'h49, 8'h41};
			8'h46: return {8'h7f, 8'h09, 8'h09, 8'h09, 8'h01};
			8'h47: return {8'h3e, 8'h41, 8'h49, 8'h49, 8'h7a};
			8'h48: return {8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f};
			8'h49: return {8'h00, 8'h41, 8'h7f, 8'h41, 8'h00};
			8'h4a: return {8'h20, 8'h40, 8'h41, 8'h3f, 8'h01};
			8'h4b: return {8'h7f, 8'h08, 8'h14, 8'h22, 8'h41};
			8'h4c: return {8'h7f, 8'h40, 8'h40, 8'h40, 8'h40};
			8'h4d: return {8'h7f, 8'h02, 8'h0c, 8'h02, 8'h7f};
			8'h4e: return {8'h7f, 8'h04, 8'h08, 8'h10, 8'h7f};
			8'h4f: return {8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e};
			8'h50: return {8'h7f, 8'h09, 8'h09, 8'h09, 8'h06};
			8'h51: return {8'h3e, 8'h41, 8'h51, 8'h21, 8'h5e};
			8'h52: return {8'h7f, 8'h09, 8'h19, 8'h29, 8'h46};
			8'h53: return {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
			8'h54: return {8'h01, 8'h01, 8'h7f, 8'h01, 8'h01};
			8'h55: return {8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f};
			8'h56: return {8'h1f, 8'h20, 8'h40, 8'h20, 8'h1f};
			8'h57: return {8'h3f, 8'h40, 8'h38, 8'h40, 8'h3f};
			8'h58: return {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
			8'h59: return {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
			8'h5a: return {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
			8'h80: return {8'h38, 8'h45, 8'h44, 8'h45, 8'h38};
			default: return 40'h0;
		endcase
	endfunction

	function automatic void blacken(input int x, input int y);
		int px;
		if (x < 0 || x >= 296 || y < 0 || y >= 128)
			return;
		px = 127 - y;
		shadow_store[px / 8 + x * 16] &= ~(8'h80 >> (px % 8));
	endfunction

	function automatic void step_cursor();
		shadow_cursor = shadow_cursor + 6 * scale;
		if (shadow_cursor > CURSOR_MAX)
			shadow_cursor = CURSOR_MAX;
	endfunction

	function automatic void render_glyph(input int code);
		logic [39:0] cols;
		logic [7:0]  colv;
		int dy, dot, dx;
		if (font_cols(code) == 40'h0)
			code = 0;
		cols = font_cols(code == UML_SLOT ? 8'h4f : code);
		for (int c = 0; c < 5; c++) begin
			colv = cols[39 - 8 * c -: 8];
			for (int r = 0; r < 7; r++)
				if (colv[r])
					for (int a = 0; a < scale; a++)
						for (int b = 0; b < scale; b++)
							blacken(shadow_cursor + c * scale + a, org_y + r * scale + b);
		end
		if (code == UML_SLOT) begin
			dy = org_y - 2 * scale;
			dot = scale > 1 ? scale : 1;
			for (int d = 0; d < 2; d++) begin
				dx = shadow_cursor + (d == 0 ? scale : 3 * scale);
				for (int a = 0; a < dot; a++)
					for (int b = 0; b < dot; b++)
						blacken(dx + a, dy + b);
			end
		end
		step_cursor();
	endfunction

	function automatic reply_t render_op(input op_t op);
		reply_t rep;
		int code;
		rep.rdata = 8'h00;
		code = op.txt;
		if (op.func == FUNC_TEXT) begin
			if (op.start) begin
				shadow_lead = 0;
				shadow_cursor = org_x;
			end
			if (shadow_lead) begin
				shadow_lead = 0;
				if (code == UML_UPPER || code == UML_LOWER) begin
					render_glyph(UML_SLOT);
					code = 256;
				end else
					step_cursor();
			end
			if (code == LEAD_BYTE) begin
				if (op.stop)
					step_cursor();
				else
					shadow_lead = 1;
			end else if (code < 256)
				render_glyph(code);
			if (op.stop && shadow_lead) begin
				shadow_lead = 0;
				step_cursor();
			end
		end else if (op.func == FUNC_CLEAR) begin
			foreach (shadow_store[i])
				shadow_store[i] = op.white ? 8'hFF : 8'h00;
		end else if (op.func == FUNC_READ) begin
			if (op.ridx < STORE_SIZE)
				rep.rdata = shadow_store[op.ridx];
		end
		rep.cursor = shadow_cursor[10:0];
		return rep;
	endfunction

	// Driver: one beat per handshake, random gaps on the sender side.
	always @(posedge clk) begin
		op_t op;
		if (s_tvalid && s_tready) begin
			op = {s_tuser, s_tdata[7:0], s_tdata[8], s_tlast, s_tdata[9], s_tdata[22:10]};
			expected_replies.push_back(render_op(op));
		end
		if (!s_tvalid || s_tready) begin
			if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				op = pending_ops.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= op.func;
				s_tlast <= op.stop;
				s_tdata <= {1'b0, op.ridx, op.white, op.start, op.txt};
			end else
				s_tvalid <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (hold_cycles > 0)
			hold_cycles <= hold_cycles - 1;
		m_tready <= hold_cycles <= 1 && $urandom_range(99) >= recv_idle_pct;
	end

	// Monitor and checker.
	always @(posedge clk) begin
		reply_t got, want;
		if (m_tvalid && m_tready) begin
			got = {m_tdata[7:0], m_tdata[18:8]};
			if (expected_replies.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: unexpected beat data=%02h cursor=%0d", got.rdata, got.cursor);
			end else begin
				want = expected_replies.pop_front();
				n_checked++;
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: beat %0d expected data=%02h cursor=%0d, got data=%02h cursor=%0d",
							n_checked, want.rdata, want.cursor, got.rdata, got.cursor);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= IDLE_LIMIT) begin
			$display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic void add_op(input logic [1:0] func, input logic [7:0] txt,
			input logic start, input logic stop, input logic white, input int ridx);
		op_t op;
		op.func = func;
		op.txt = txt;
		op.start = start;
		op.stop = stop;
		op.white = white;
		op.ridx = 13'(ridx);
		pending_ops.push_back(op);
		if (func == FUNC_TEXT) n_text++;
		else if (func == FUNC_CLEAR) n_clear++;
		else n_read++;
	endfunction

	function automatic void add_read_near();
		int x;
		x = org_x + $urandom_range(6 * 8 * scale);
		if (x > 295)
			x = $urandom_range(295);
		add_op(FUNC_READ, 8'($urandom), 0, 0, 1'($urandom), x * 16 + $urandom_range(15));
	endfunction

	function automatic logic [7:0] pick_char();
		string glyphs;
		glyphs = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789!%-.: ";
		case ($urandom_range(9))
			0: return 8'($urandom);
			1: return UML_SLOT;
			default: return glyphs[$urandom_range(glyphs.len() - 1)];
		endcase
	endfunction

	function automatic void add_string(input int len);
		logic [7:0] b;
		int k;
		bit broken;
		broken = $urandom_range(9) == 0;
		k = 0;
		while (k < len) begin
			if ($urandom_range(5) == 0) begin
				add_op(FUNC_TEXT, LEAD_BYTE, k == 0, k == len - 1 && !broken, 1'($urandom),
					$urandom);
				k++;
				if (k < len && $urandom_range(3) != 0) begin
					b = $urandom_range(1) ? UML_UPPER : UML_LOWER;
					add_op(FUNC_TEXT, b, 0, k == len - 1 && !broken, 1'($urandom), $urandom);
					k++;
				end
			end else begin
				add_op(FUNC_TEXT, pick_char(), k == 0 || (broken && $urandom_range(3) == 0),
					k == len - 1 && !broken, 1'($urandom), $urandom);
				k++;
			end
		end
	endfunction

	task automatic write_regs(input int x, input int y, input int s);
		org_x = x;
		org_y = y;
		scale = s;
		cfg_we <= 1'b1;
		cfg_index <= REG_ORIGIN_X;
		cfg_data <= 9'(x);
		@(posedge clk);
		cfg_index <= REG_ORIGIN_Y;
		cfg_data <= 9'(y);
		@(posedge clk);
		cfg_index <= REG_SCALE;
		cfg_data <= 9'(s);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_ops.size() != 0 || s_tvalid || expected_replies.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	initial begin
		int px, py, ps, budget;
		foreach (shadow_store[i])
			shadow_store[i] = 8'h00;
		shadow_cursor = 0;
		shadow_lead = 0;
		org_x = 0;
		org_y = 0;
		scale = 1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_regs(4, 20, 2);
		add_op(FUNC_CLEAR, 0, 0, 0, 1, 0);
		add_op(FUNC_TEXT, "A", 1, 0, 0, 0);
		add_op(FUNC_TEXT, "%", 0, 0, 0, 0);
		add_op(FUNC_TEXT, 8'h00, 0, 0, 0, 0);
		add_op(FUNC_TEXT, 8'hFF, 0, 0, 0, 0);
		add_op(FUNC_TEXT, LEAD_BYTE, 0, 0, 0, 0);
		add_op(FUNC_TEXT, UML_UPPER, 0, 0, 0, 0);
		add_op(FUNC_TEXT, LEAD_BYTE, 0, 0, 0, 0);
		add_op(FUNC_TEXT, UML_LOWER, 0, 0, 0, 0);
		add_op(FUNC_TEXT, LEAD_BYTE, 0, 0, 0, 0);
		add_op(FUNC_TEXT, "Z", 0, 0, 0, 0);
		add_op(FUNC_TEXT, UML_SLOT, 0, 0, 0, 0);
		add_op(FUNC_TEXT, " ", 0, 0, 0, 0);
		add_op(FUNC_TEXT, LEAD_BYTE, 0, 1, 0, 0);
		add_op(FUNC_TEXT, LEAD_BYTE, 1, 0, 0, 0);
		add_op(FUNC_TEXT, "9", 1, 1, 0, 0);
		for (int i = 0; i < 4; i++)
			add_read_near();
		add_op(FUNC_READ, 0, 0, 0, 0, 0);
		add_op(FUNC_READ, 0, 0, 0, 0, STORE_SIZE - 1);
		add_op(FUNC_CLEAR, 0, 0, 0, 0, 0);
		add_op(FUNC_READ, 0, 0, 0, 0, 4096);
		add_op(FUNC_CLEAR, 0, 0, 0, 1, 0);
		drain();

		for (int phase = 0; phase < 9; phase++) begin
			case (phase)
				0: begin px = 0; py = 0; ps = 1; end
				1: begin px = 295; py = 127; ps = 8; end
				2: begin px = 250; py = 2; ps = 3; end
				3: begin px = 10; py = 60; ps = 2; end
				4: begin px = 0; py = 120; ps = 8; end
				default: begin
					px = $urandom_range(295);
					py = $urandom_range(127);
					ps = $urandom_range(8, 1);
				end
			endcase
			if (phase < 3) begin
				send_idle_pct = 30;
				recv_idle_pct = 50;
			end else if (phase < 6) begin
				send_idle_pct = 50;
				recv_idle_pct = 30;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_regs(px, py, ps);
			if (phase == 1)
				add_string(40);
			if (phase == 6)
				hold_cycles = 400;
			budget = 30;
			while (budget > 0) begin
				case ($urandom_range(19))
					0: add_op(FUNC_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom),
						$urandom_range(3) != 0, $urandom);
					1, 2, 3, 4: add_read_near();
					default: add_string($urandom_range(8, 1));
				endcase
				budget = budget - 3;
			end
			for (int i = 0; i < 4; i++)
				add_read_near();
			drain();
		end

		$display("Covered %0d text beats, %0d clears and %0d read-backs; %0d replies checked.",
			n_text, n_clear, n_read, n_checked);
		$display("Scale 1 to 8, origins at both screen edges, umlaut pairs and orphan leads.");
		if (errors == 0)
			$display("*** PASSED ***");
		else begin
			$display("%0d mismatches", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hdl/gtr_pkg.sv
hdl/gtr_ram.sv
hdl/gtr_datapath.sv
hdl/gtr_ctrl.sv
hdl/glyph_text_rasterizer.sv
verif/tb_top.sv
